>>> rtl/core/c2d_pkg.sv
package c2d_pkg;

    // field widths of the item and result beats
    localparam int OP_W     = 2;
    localparam int KIDX_W   = 4;
    localparam int CHAN_W   = 2;
    localparam int TAP_W    = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 38;

    // configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int EXT_REG_W  = 7;
    localparam int HALF_REG_W = 2;

    // default storage sizes
    localparam int DEF_MAX_DIM         = 64;
    localparam int DEF_MAX_CHANNELS    = 4;
    localparam int DEF_MAX_KERNELS     = 16;
    localparam int DEF_MAX_KERNEL_SIZE = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HALF_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HALF_HEIGHT = 2'd3;

    // item operations
    typedef enum logic [OP_W-1:0] {
        OP_WEIGHT  = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control from the tap sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

>>> rtl/core/c2d_if.sv
interface c2d_in_if import c2d_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [KIDX_W-1:0]        kernel_index;
    logic [CHAN_W-1:0]        source_channel;
    logic [TAP_W-1:0]         tap_x;
    logic [TAP_W-1:0]         tap_y;
    logic [POS_W-1:0]         x_pos;
    logic [POS_W-1:0]         y_pos;
    logic signed [VAL_W-1:0]  value;

    modport source (
        output valid, operation, kernel_index, source_channel, tap_x, tap_y,
               x_pos, y_pos, value,
        input  ready
    );
    modport sink (
        input  valid, operation, kernel_index, source_channel, tap_x, tap_y,
               x_pos, y_pos, value,
        output ready
    );
endinterface

interface c2d_out_if import c2d_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [SUM_W-1:0]  sum_value;
    logic                     range_error;

    modport source (
        output valid, sum_value, range_error,
        input  ready
    );
    modport sink (
        input  valid, sum_value, range_error,
        output ready
    );
endinterface

interface c2d_cfg_if import c2d_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/core/c2d_mac.sv
module c2d_mac import c2d_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [VAL_W-1:0]  sample,
    input  logic signed [VAL_W-1:0]  weight,
    output logic signed [SUM_W-1:0]  acc,
    output logic                     busy
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  prod_ext;

    // product valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.valid;
        end
    end

    // registered product of one tap
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            prod_reg <= sample * weight;
        end
    end

    assign prod_ext = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // exact accumulator, cleared at the start of a request
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

>>> rtl/core/conv2d_clamped_border_forward.sv
// 2-D convolution with replicate padding over a multi-channel sample memory and a
// weight memory. Weight and sample writes are taken while the block is idle. An output
// request reads one tap per cycle from the single read port of the sample memory; each
// tap is then multiplied and added to a 38-bit exact sum. A request that lies outside
// the image in use answers with range_error set and a zero sum. The block takes no
// item while a request is being worked on; a finished result waits in the output
// register while the next item is taken. Both memories come out of reset with
// undefined contents and need no clearing.
module conv2d_clamped_border_forward import c2d_pkg::*; #(
    parameter int MAX_DIM         = DEF_MAX_DIM,
    parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS,
    parameter int MAX_KERNELS     = DEF_MAX_KERNELS,
    parameter int MAX_KERNEL_SIZE = DEF_MAX_KERNEL_SIZE
) (
    input  logic       clk,
    input  logic       rst_n,
    c2d_in_if.sink     item,
    c2d_out_if.source  result,
    c2d_cfg_if.sink    cfg
);

    localparam int SA_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int WA_DEPTH = MAX_KERNELS * MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
    localparam int SA_W     = (SA_DEPTH > 1) ? $clog2(SA_DEPTH) : 1;
    localparam int WA_W     = (WA_DEPTH > 1) ? $clog2(WA_DEPTH) : 1;
    localparam int KI_W     = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int KC_W     = (MAX_KERNEL_SIZE > 1) ? $clog2(MAX_KERNEL_SIZE) : 1;
    localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int XW_RAW   = $clog2(MAX_DIM + 1);
    localparam int XW       = (XW_RAW > EXT_REG_W) ? XW_RAW : EXT_REG_W;
    localparam int CRD_W    = XW + 2;
    localparam int HALF_MAX = (MAX_KERNEL_SIZE - 1) / 2;

    // configuration registers
    logic [EXT_REG_W-1:0]  image_width_reg;
    logic [EXT_REG_W-1:0]  image_height_reg;
    logic [HALF_REG_W-1:0] kernel_half_width_reg;
    logic [HALF_REG_W-1:0] kernel_half_height_reg;

    // control state
    state_t state_reg;
    state_t state_next;
    logic   rd_vld_reg;
    logic   result_vld_reg;

    // request context
    logic [KI_W-1:0]       kern_reg;
    logic [POS_W-1:0]      xp_reg;
    logic [POS_W-1:0]      yp_reg;
    logic [CHAN_W-1:0]     src_reg;
    logic [XW-1:0]         w_reg;
    logic [XW-1:0]         h_reg;
    logic [HALF_REG_W-1:0] hw_reg;
    logic [HALF_REG_W-1:0] hh_reg;
    logic                  err_reg;
    logic [KC_W-1:0]       p_reg;
    logic [KC_W-1:0]       q_reg;

    // result register
    logic signed [SUM_W-1:0] result_sum_reg;
    logic                    result_err_reg;

    // memories
    logic [VAL_W-1:0]  sample_mem [SA_DEPTH];
    logic [VAL_W-1:0]  weight_mem [WA_DEPTH];
    logic [VAL_W-1:0]  sample_q_reg;
    logic [VAL_W-1:0]  weight_q_reg;
    logic [CHAN_W-1:0] ksrc_reg [MAX_KERNELS];

    logic              item_acc;
    op_t               op;
    logic              weight_we;
    logic              sample_we;
    logic              start;
    logic              issue;
    logic              load_result;
    logic              last_tap;
    logic [KC_W-1:0]   p_last;
    logic [KC_W-1:0]   q_last;
    logic [XW-1:0]     w_use;
    logic [XW-1:0]     h_use;
    logic [HALF_REG_W-1:0] hw_use;
    logic [HALF_REG_W-1:0] hh_use;
    logic              req_err;
    logic [CHAN_W-1:0] ksrc_rd;
    logic [SA_W-1:0]   s_waddr;
    logic [SA_W-1:0]   s_raddr;
    logic [WA_W-1:0]   w_waddr;
    logic [WA_W-1:0]   w_raddr;
    logic signed [CRD_W-1:0] x_tap;
    logic signed [CRD_W-1:0] y_tap;
    logic [DIM_W-1:0]  r_coord;
    logic [DIM_W-1:0]  s_coord;
    mac_ctrl_t         mac_ctrl;
    logic signed [SUM_W-1:0] mac_acc;
    logic              mac_busy;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg        <= EXT_REG_W'(64);
            image_height_reg       <= EXT_REG_W'(64);
            kernel_half_width_reg  <= HALF_REG_W'(1);
            kernel_half_height_reg <= HALF_REG_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:        image_width_reg        <= cfg.data;
                CFG_IMAGE_HEIGHT:       image_height_reg       <= cfg.data;
                CFG_KERNEL_HALF_WIDTH:  kernel_half_width_reg  <= cfg.data[HALF_REG_W-1:0];
                CFG_KERNEL_HALF_HEIGHT: kernel_half_height_reg <= cfg.data[HALF_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes in use
    always_comb
    begin
        if (image_width_reg == '0)
            w_use = XW'(1);
        else if (XW'(image_width_reg) > XW'(MAX_DIM))
            w_use = XW'(MAX_DIM);
        else
            w_use = XW'(image_width_reg);

        if (image_height_reg == '0)
            h_use = XW'(1);
        else if (XW'(image_height_reg) > XW'(MAX_DIM))
            h_use = XW'(MAX_DIM);
        else
            h_use = XW'(image_height_reg);

        hw_use = (32'(kernel_half_width_reg) > HALF_MAX) ? HALF_REG_W'(HALF_MAX)
                                                         : kernel_half_width_reg;
        hh_use = (32'(kernel_half_height_reg) > HALF_MAX) ? HALF_REG_W'(HALF_MAX)
                                                          : kernel_half_height_reg;
    end

    // item decode
    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign op         = op_t'(item.operation);

    always_comb
    begin
        weight_we = 1'b0;
        sample_we = 1'b0;
        start     = 1'b0;
        if (item_acc)
        begin
            unique case (op)
                OP_WEIGHT:
                    weight_we = (32'(item.kernel_index) < MAX_KERNELS) &&
                                (32'(item.tap_x) < MAX_KERNEL_SIZE) &&
                                (32'(item.tap_y) < MAX_KERNEL_SIZE) &&
                                (32'(item.source_channel) < MAX_CHANNELS);
                OP_SAMPLE:
                    sample_we = (32'(item.source_channel) < MAX_CHANNELS) &&
                                (32'(item.x_pos) < MAX_DIM) &&
                                (32'(item.y_pos) < MAX_DIM);
                OP_COMPUTE:
                    start = 1'b1;
                default: ;
            endcase
        end
    end

    assign req_err = (32'(item.kernel_index) >= MAX_KERNELS) ||
                     (XW'(item.x_pos) >= w_use) || (XW'(item.y_pos) >= h_use);
    assign ksrc_rd = ksrc_reg[KI_W'(item.kernel_index)];

    // kernel source table, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_KERNELS; i++)
            begin
                ksrc_reg[i] <= '0;
            end
        end
        else if (weight_we)
        begin
            ksrc_reg[KI_W'(item.kernel_index)] <= item.source_channel;
        end
    end

    // write addresses
    assign s_waddr = SA_W'((32'(item.source_channel) * MAX_DIM + 32'(item.x_pos)) * MAX_DIM
                           + 32'(item.y_pos));
    assign w_waddr = WA_W'((32'(item.kernel_index) * MAX_KERNEL_SIZE + 32'(item.tap_x))
                           * MAX_KERNEL_SIZE + 32'(item.tap_y));

    // tap coordinates clamped to the image edge
    always_comb
    begin
        x_tap = $signed(CRD_W'(xp_reg)) + $signed(CRD_W'(p_reg)) - $signed(CRD_W'(hw_reg));
        y_tap = $signed(CRD_W'(yp_reg)) + $signed(CRD_W'(q_reg)) - $signed(CRD_W'(hh_reg));

        if (x_tap < 0)
            r_coord = '0;
        else if (x_tap >= $signed(CRD_W'(w_reg)))
            r_coord = DIM_W'(w_reg - XW'(1));
        else
            r_coord = DIM_W'(x_tap);

        if (y_tap < 0)
            s_coord = '0;
        else if (y_tap >= $signed(CRD_W'(h_reg)))
            s_coord = DIM_W'(h_reg - XW'(1));
        else
            s_coord = DIM_W'(y_tap);
    end

    // read addresses
    assign s_raddr = SA_W'((32'(src_reg) * MAX_DIM + 32'(r_coord)) * MAX_DIM + 32'(s_coord));
    assign w_raddr = WA_W'((32'(kern_reg) * MAX_KERNEL_SIZE + 32'(p_reg)) * MAX_KERNEL_SIZE
                           + 32'(q_reg));

    // sample memory
    always_ff @(posedge clk)
    begin
        if (sample_we)
        begin
            sample_mem[s_waddr] <= item.value;
        end
        sample_q_reg <= sample_mem[s_raddr];
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[w_waddr] <= item.value;
        end
        weight_q_reg <= weight_mem[w_raddr];
    end

    // tap sequence end
    assign p_last   = KC_W'({hw_reg, 1'b0});
    assign q_last   = KC_W'({hh_reg, 1'b0});
    assign last_tap = (p_reg == p_last) && (q_reg == q_last);

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        issue       = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = req_err ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_vld_reg || result.ready)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_vld_reg     <= 1'b0;
            result_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (load_result)
                result_vld_reg <= 1'b1;
            else if (result.ready)
                result_vld_reg <= 1'b0;
        end
    end

    // request context and tap counters
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kern_reg <= KI_W'(item.kernel_index);
            xp_reg   <= item.x_pos;
            yp_reg   <= item.y_pos;
            src_reg  <= (32'(ksrc_rd) >= MAX_CHANNELS) ? '0 : ksrc_rd;
            w_reg    <= w_use;
            h_reg    <= h_use;
            hw_reg   <= hw_use;
            hh_reg   <= hh_use;
            err_reg  <= req_err;
            p_reg    <= '0;
            q_reg    <= '0;
        end
        else if (issue)
        begin
            if (q_reg == q_last)
            begin
                q_reg <= '0;
                p_reg <= p_reg + KC_W'(1);
            end
            else
            begin
                q_reg <= q_reg + KC_W'(1);
            end
        end
    end

    // multiply-accumulate
    assign mac_ctrl.clear = start;
    assign mac_ctrl.valid = rd_vld_reg;

    c2d_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample ($signed(sample_q_reg)),
        .weight ($signed(weight_q_reg)),
        .acc    (mac_acc),
        .busy   (mac_busy)
    );

    // result beat
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_sum_reg <= err_reg ? '0 : mac_acc;
            result_err_reg <= err_reg;
        end
    end

    assign result.valid       = result_vld_reg;
    assign result.sum_value   = result_sum_reg;
    assign result.range_error = result_err_reg;

    // checks
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.range_error |-> result.sum_value == '0)
        else $error("range error result carries a nonzero sum");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !rd_vld_reg && !mac_busy)
        else $error("tap pipeline active while idle");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> p_reg <= p_last && q_reg <= q_last)
        else $error("tap counter beyond kernel size");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

endmodule

>>> sim/c2d_conv_checker.sv
module c2d_conv_checker import c2d_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    c2d_in_if    item,
    c2d_out_if   result,
    c2d_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding,
    output int   sums_seen,
    output int   range_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic                    range_error;
    } conv_out_t;

    // shadow copy of the block state
    logic signed [VAL_W-1:0] sample_mem [DEF_MAX_CHANNELS][DEF_MAX_DIM][DEF_MAX_DIM];
    logic signed [VAL_W-1:0] weight_mem [DEF_MAX_KERNELS][DEF_MAX_KERNEL_SIZE]
                                        [DEF_MAX_KERNEL_SIZE];
    logic [CHAN_W-1:0]       kernel_chan [DEF_MAX_KERNELS];
    logic [EXT_REG_W-1:0]    img_w;
    logic [EXT_REG_W-1:0]    img_h;
    logic [HALF_REG_W-1:0]   half_w;
    logic [HALF_REG_W-1:0]   half_h;

    // outputs still owed by the block, oldest first
    conv_out_t due_sums [$];

    function automatic int extent_of(input logic [EXT_REG_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > DEF_MAX_DIM)
            return DEF_MAX_DIM;
        return int'(r);
    endfunction

    function automatic int edge_clamp(input int v, input int extent);
        if (v < 0)
            return 0;
        if (v > extent - 1)
            return extent - 1;
        return v;
    endfunction

    // one output: replicate-padded window sum, exact in the accumulator width
    function automatic conv_out_t conv_at(input logic [KIDX_W-1:0] k,
                                          input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y);
        conv_out_t r;
        int        w;
        int        h;
        int        hw;
        int        hh;
        int        cx;
        int        cy;
        longint    acc;
        w   = extent_of(img_w);
        h   = extent_of(img_h);
        hw  = int'(half_w) > (DEF_MAX_KERNEL_SIZE - 1) / 2 ? (DEF_MAX_KERNEL_SIZE - 1) / 2
                                                          : int'(half_w);
        hh  = int'(half_h) > (DEF_MAX_KERNEL_SIZE - 1) / 2 ? (DEF_MAX_KERNEL_SIZE - 1) / 2
                                                          : int'(half_h);
        acc = 0;
        if (int'(x) >= w || int'(y) >= h) begin
            r.sum         = '0;
            r.range_error = 1'b1;
            return r;
        end
        for (int p = 0; p <= 2 * hw; p++) begin
            cx = edge_clamp(int'(x) + p - hw, w);
            for (int q = 0; q <= 2 * hh; q++) begin
                cy = edge_clamp(int'(y) + q - hh, h);
                acc += longint'(sample_mem[kernel_chan[k]][cx][cy]) *
                       longint'(weight_mem[k][p][q]);
            end
        end
        r.sum         = acc[SUM_W-1:0];
        r.range_error = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        conv_out_t due;
        if (!rst_n) begin
            img_w  = EXT_REG_W'(DEF_MAX_DIM);
            img_h  = EXT_REG_W'(DEF_MAX_DIM);
            half_w = HALF_REG_W'(1);
            half_h = HALF_REG_W'(1);
            for (int k = 0; k < DEF_MAX_KERNELS; k++)
                kernel_chan[k] = '0;
            due_sums.delete();
            mismatches  = 0;
            sums_seen   = 0;
            range_hits  = 0;
            outstanding <= 0;
        end
        else begin
            // register writes
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_IMAGE_WIDTH:        img_w  = cfg.data[EXT_REG_W-1:0];
                    CFG_IMAGE_HEIGHT:       img_h  = cfg.data[EXT_REG_W-1:0];
                    CFG_KERNEL_HALF_WIDTH:  half_w = cfg.data[HALF_REG_W-1:0];
                    CFG_KERNEL_HALF_HEIGHT: half_h = cfg.data[HALF_REG_W-1:0];
                    default: ;
                endcase
            end

            // result beat against the oldest owed output
            if (result.valid && result.ready) begin
                if (due_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: sum %0d range_error %0b",
                                 result.sum_value, result.range_error);
                end
                else begin
                    due = due_sums.pop_front();
                    sums_seen++;
                    if (due.range_error)
                        range_hits++;
                    if (result.sum_value !== due.sum ||
                        result.range_error !== due.range_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: sum exp %0d got %0d, %s %0b got %0b",
                                     due.sum, result.sum_value, "range_error exp",
                                     due.range_error, result.range_error);
                    end
                end
            end

            // item beat updates the shadow state or owes a new output
            if (item.valid && item.ready) begin
                case (item.operation)
                    OP_WEIGHT: begin
                        if (item.tap_x < DEF_MAX_KERNEL_SIZE &&
                            item.tap_y < DEF_MAX_KERNEL_SIZE) begin
                            weight_mem[item.kernel_index][item.tap_x][item.tap_y] = item.value;
                            kernel_chan[item.kernel_index] = item.source_channel;
                        end
                    end
                    OP_SAMPLE:
                        sample_mem[item.source_channel][item.x_pos][item.y_pos] = item.value;
                    OP_COMPUTE:
                        due_sums.insert(due_sums.size(),
                                        conv_at(item.kernel_index, item.x_pos, item.y_pos));
                    default: ;
                endcase
            end
            outstanding <= due_sums.size();
        end
    end

endmodule

>>> sim/tb_top.sv
module tb_top import c2d_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 60;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEM_BUDGET     = 450;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic sink_ready = 1'b0;
    bit   quiet      = 1'b0;
    bit   extreme_fill = 1'b0;
    int   ready_hold = 0;
    int   mismatches;
    int   outstanding;
    int   sums_seen;
    int   range_hits;
    int   settings_done = 0;
    int   writes_done   = 0;
    int   items_sent    = 0;
    int   phase_goal    = 0;

    // what the stimulus has written so far, so no unwritten entry is ever read
    bit                sample_set [DEF_MAX_CHANNELS][DEF_MAX_DIM][DEF_MAX_DIM];
    bit                weight_set [DEF_MAX_KERNELS][DEF_MAX_KERNEL_SIZE][DEF_MAX_KERNEL_SIZE];
    logic [CHAN_W-1:0] chan_of [DEF_MAX_KERNELS] = '{default: '0};
    int                eff_w  = DEF_MAX_DIM;
    int                eff_h  = DEF_MAX_DIM;
    int                eff_hw = 1;
    int                eff_hh = 1;

    c2d_in_if  item_bus ();
    c2d_out_if out_bus ();
    c2d_cfg_if cfg_bus ();

    assign out_bus.ready = sink_ready;

    conv2d_clamped_border_forward u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (out_bus),
        .cfg    (cfg_bus)
    );

    c2d_conv_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_bus),
        .result      (out_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .sums_seen   (sums_seen),
        .range_hits  (range_hits)
    );

    always #1 clk = ~clk;

    // result sink: bursts of stall and of flow, always ready in the quiet part
    always @(posedge clk) begin
        if (quiet)
            sink_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else begin
            sink_ready <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(0, 13);
        end
    end

    function automatic int clamp_to(input int v, input int extent);
        if (v < 0)
            return 0;
        if (v > extent - 1)
            return extent - 1;
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] fill_value();
        return extreme_fill ? 16'h8000 : VAL_W'($urandom);
    endfunction

    // request coordinate: anywhere, near either edge, or inside the image
    function automatic logic [POS_W-1:0] pick_pos(input int extent);
        case ($urandom_range(0, 4))
            0:       return POS_W'($urandom);
            1:       return POS_W'($urandom_range(0, extent > 3 ? 3 : extent - 1));
            2:       return POS_W'(extent - 1 - $urandom_range(0, extent > 3 ? 3 : extent - 1));
            default: return POS_W'($urandom_range(0, extent - 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(DEF_MAX_DIM + 1, 127));
            2, 3, 4: return CFG_DATA_W'($urandom_range(1, 8));
            default: return CFG_DATA_W'($urandom_range(1, DEF_MAX_DIM));
        endcase
    endfunction

    // one item beat, with an optional idle burst in front of it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KIDX_W-1:0] k,
                             input logic [CHAN_W-1:0] c, input logic [TAP_W-1:0] tx,
                             input logic [TAP_W-1:0] ty, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [VAL_W-1:0] v);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_bus.valid          <= 1'b1;
        item_bus.operation      <= op;
        item_bus.kernel_index   <= k;
        item_bus.source_channel <= c;
        item_bus.tap_x          <= tx;
        item_bus.tap_y          <= ty;
        item_bus.x_pos          <= x;
        item_bus.y_pos          <= y;
        item_bus.value          <= v;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        items_sent++;
        if (op == OP_WEIGHT && tx < DEF_MAX_KERNEL_SIZE && ty < DEF_MAX_KERNEL_SIZE) begin
            weight_set[k][tx][ty] = 1'b1;
            chan_of[k] = c;
        end
        else if (op == OP_SAMPLE)
            sample_set[c][x][y] = 1'b1;
        if (op == OP_WEIGHT || op == OP_SAMPLE)
            writes_done++;
    endtask

    // output request, preceded by writes of any tap it would read unwritten
    task automatic request(input logic [KIDX_W-1:0] k, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y);
        int sx;
        int sy;
        if (int'(x) < eff_w && int'(y) < eff_h) begin
            for (int p = 0; p <= 2 * eff_hw; p++) begin
                sx = clamp_to(int'(x) + p - eff_hw, eff_w);
                for (int q = 0; q <= 2 * eff_hh; q++) begin
                    sy = clamp_to(int'(y) + q - eff_hh, eff_h);
                    if (!weight_set[k][p][q])
                        send_item(OP_WEIGHT, k, chan_of[k], TAP_W'(p), TAP_W'(q),
                                  POS_W'($urandom), POS_W'($urandom), fill_value());
                    if (!sample_set[chan_of[k]][sx][sy])
                        send_item(OP_SAMPLE, KIDX_W'($urandom), chan_of[k], TAP_W'($urandom),
                                  TAP_W'($urandom), POS_W'(sx), POS_W'(sy), fill_value());
                end
            end
        end
        send_item(OP_COMPUTE, k, CHAN_W'($urandom), TAP_W'($urandom), TAP_W'($urandom),
                  x, y, VAL_W'($urandom));
    endtask

    // stop sending and wait until the block has nothing left in flight
    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // new register setting, written only once the block is idle
    task automatic set_phase(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                             input logic [CFG_DATA_W-1:0] hwd,
                             input logic [CFG_DATA_W-1:0] hhd);
        drain();
        cfg_beat(CFG_IMAGE_WIDTH, wd);
        cfg_beat(CFG_IMAGE_HEIGHT, hd);
        cfg_beat(CFG_KERNEL_HALF_WIDTH, hwd);
        cfg_beat(CFG_KERNEL_HALF_HEIGHT, hhd);
        cfg_bus.valid <= 1'b0;
        eff_w  = (wd == 0) ? 1 : (wd > DEF_MAX_DIM ? DEF_MAX_DIM : int'(wd));
        eff_h  = (hd == 0) ? 1 : (hd > DEF_MAX_DIM ? DEF_MAX_DIM : int'(hd));
        eff_hw = int'(hwd[HALF_REG_W-1:0]);
        eff_hh = int'(hhd[HALF_REG_W-1:0]);
        settings_done++;
    endtask

    task automatic random_item();
        int               pick;
        logic [TAP_W-1:0] tx;
        logic [TAP_W-1:0] ty;
        pick = $urandom_range(0, 99);
        tx   = ($urandom_range(0, 9) == 0) ? TAP_W'(7) : TAP_W'($urandom_range(0, 6));
        ty   = ($urandom_range(0, 9) == 0) ? TAP_W'(7) : TAP_W'($urandom_range(0, 6));
        if (pick < 30)
            send_item(OP_WEIGHT, KIDX_W'($urandom), CHAN_W'($urandom), tx, ty,
                      POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        else if (pick < 60)
            send_item(OP_SAMPLE, KIDX_W'($urandom), CHAN_W'($urandom), tx, ty,
                      ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                                  : POS_W'($urandom_range(0, eff_w - 1)),
                      ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                                  : POS_W'($urandom_range(0, eff_h - 1)),
                      VAL_W'($urandom));
        else if (pick < 95)
            request(KIDX_W'($urandom), pick_pos(eff_w), pick_pos(eff_h));
        else
            send_item(OP_UNUSED, KIDX_W'($urandom), CHAN_W'($urandom), tx, ty,
                      POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
    endtask

    initial begin
        item_bus.valid          = 1'b0;
        item_bus.operation      = '0;
        item_bus.kernel_index   = '0;
        item_bus.source_channel = '0;
        item_bus.tap_x          = '0;
        item_bus.tap_y          = '0;
        item_bus.x_pos          = '0;
        item_bus.y_pos          = '0;
        item_bus.value          = '0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = '0;
        cfg_bus.data            = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // full image, 3x3 kernel
        set_phase(7'd64, 7'd64, 7'd1, 7'd1);
        // most negative weights and samples at the corner, with the taps off the image clamped
        extreme_fill = 1'b1;
        request(4'd0, 6'd0, 6'd0);
        extreme_fill = 1'b0;
        request(4'd0, 6'd63, 6'd63);
        // weight writes with a tap outside the store are dropped, channel kept
        send_item(OP_WEIGHT, 4'd15, 2'd3, 3'd7, 3'd3, 6'd0, 6'd0, VAL_W'($urandom));
        send_item(OP_WEIGHT, 4'd15, 2'd3, 3'd2, 3'd7, 6'd0, 6'd0, VAL_W'($urandom));
        request(4'd15, 6'd31, 6'd0);
        // largest positive product in the far corner of the last channel
        send_item(OP_SAMPLE, 4'd0, 2'd3, 3'd0, 3'd0, 6'd63, 6'd63, 16'h7FFF);
        send_item(OP_WEIGHT, 4'd4, 2'd3, 3'd1, 3'd1, 6'd0, 6'd0, 16'h7FFF);
        request(4'd4, 6'd63, 6'd63);
        // unknown operation gives nothing
        send_item(OP_UNUSED, 4'd9, 2'd1, 3'd5, 3'd2, 6'd12, 6'd40, VAL_W'($urandom));
        request(4'd0, 6'd62, 6'd63);

        // single pixel image, 1x1 kernel, one request on the image and two off it
        set_phase(7'd1, 7'd1, 7'd0, 7'd0);
        request(4'd3, 6'd0, 6'd0);
        request(4'd3, 6'd5, 6'd0);
        request(4'd3, 6'd0, 6'd63);

        // largest kernel at full size
        set_phase(7'd64, 7'd64, 7'd3, 7'd3);
        extreme_fill = 1'b1;
        request(4'd1, 6'd63, 6'd0);
        extreme_fill = 1'b0;
        request(4'd1, 6'd30, 6'd30);

        // extents of zero and above the maximum, half sizes with high bits set
        set_phase(7'd0, 7'd127, 7'h7E, 7'h40);
        request(4'd2, 6'd1, 6'd5);
        request(4'd2, 6'd0, 6'd63);

        // random phases share what is left of the item budget, the last one without idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_phase(pick_extent(), pick_extent(), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom));
            if (ph == RANDOM_PHASES - 1)
                quiet = 1'b1;
            phase_goal = items_sent + (ITEM_BUDGET - items_sent) / (RANDOM_PHASES - ph);
            while (items_sent < phase_goal)
                random_item();
        end
        drain();

        $display("covered %0d output requests (%0d out of range) and %0d store writes",
                 sums_seen, range_hits, writes_done);
        $display("across %0d register settings with random stalls on both channels",
                 settings_done);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
